FILE: design/sgsm_pkg.sv
// Shared widths, constants and types for the sparse grid second moment block.
package sgsm_pkg;

   localparam int DATA_W        = 64;
   localparam int DIM_W         = 4;
   localparam int LEVEL_W       = 4;
   localparam int INDEX_W       = 16;
   localparam int MAX_DIMS_DEF  = 16;
   localparam int MAX_LEVEL_DEF = 15;

   // Item kinds on the request channel.
   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TERM = 1'b1;

   // Q32.32 constants, truncated.
   localparam logic [DATA_W-1:0] Q_ONE    = 64'h0000_0001_0000_0000;
   localparam logic [DATA_W-1:0] S_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [DATA_W-1:0] S_MIN    = 64'h8000_0000_0000_0000;
   localparam logic [DATA_W-1:0] M2_L0_I0 = 64'd1073741824;   // 1/4
   localparam logic [DATA_W-1:0] M2_L0_I1 = 64'd357913941;    // 1/12
   localparam logic [31:0]       M2_SIXTH = 32'd715827882;    // 1/6 fraction
   localparam logic [DATA_W-1:0] M1_L0_I0 = 64'd1431655765;   // 1/3
   localparam logic [DATA_W-1:0] M1_L0_I1 = 64'd715827882;    // 1/6
   localparam logic [DATA_W-1:0] Q_L0     = 64'd2147483648;   // 1/2

   typedef struct packed {
      logic              start;
      logic [DATA_W-1:0] op_a;
      logic [DATA_W-1:0] op_b;
   } qmul_req_type;

   typedef struct packed {
      logic              done;
      logic              sat;
      logic [DATA_W-1:0] prod;
   } qmul_rsp_type;

endpackage

FILE: design/sgsm_req_if.sv
// Request channel: bound loads and grid point terms.
interface sgsm_req_if
   import sgsm_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic                      cmd;
   logic [DIM_W-1:0]          dim;
   logic [LEVEL_W-1:0]        level;
   logic [INDEX_W-1:0]        index;
   logic signed [DATA_W-1:0]  lower;
   logic signed [DATA_W-1:0]  upper;
   logic signed [DATA_W-1:0]  alpha;
   logic                      last_dim;
   logic                      last_point;

   modport source (
      output valid, cmd, dim, level, index, lower, upper, alpha, last_dim, last_point,
      input  ready
   );
   modport sink (
      input  valid, cmd, dim, level, index, lower, upper, alpha, last_dim, last_point,
      output ready
   );
endinterface

FILE: design/sgsm_rsp_if.sv
// Response channel: accumulated second moment and saturation flag.
interface sgsm_rsp_if
   import sgsm_pkg::*;
();
   logic                      valid;
   logic                      ready;
   logic signed [DATA_W-1:0]  moment;
   logic                      saturated;

   modport source (
      output valid, moment, saturated,
      input  ready
   );
   modport sink (
      input  valid, moment, saturated,
      output ready
   );
endinterface

FILE: design/sgsm_qmul.sv
// Iterative signed Q32.32 multiplier built on one 32x32 partial product unit.
module sgsm_qmul
   import sgsm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  qmul_req_type mul_req,
   output qmul_rsp_type mul_rsp
);

   logic              busy_ff, busy_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic              neg_ff, neg_in;
   logic [DATA_W-1:0] ma_ff, ma_in;
   logic [DATA_W-1:0] mb_ff, mb_in;
   logic [DATA_W-1:0] pp_ff, pp_in;
   logic [127:0]      acc_ff, acc_in;
   qmul_rsp_type      rsp_ff, rsp_in;

   logic [31:0]       a_part, b_part;
   logic [127:0]      addend;
   logic [127:0]      sgn;
   logic              ovf;

   always_comb begin
      // Partial products in order: lo*lo, lo*hi, hi*lo, hi*hi.
      a_part = cnt_ff[1] ? ma_ff[63:32] : ma_ff[31:0];
      b_part = cnt_ff[0] ? mb_ff[63:32] : mb_ff[31:0];

      unique case (cnt_ff)
         3'd1:       addend = {64'd0, pp_ff};
         3'd2, 3'd3: addend = {32'd0, pp_ff, 32'd0};
         3'd4:       addend = {pp_ff, 64'd0};
         default:    addend = '0;
      endcase

      sgn = neg_ff ? (~acc_ff + 128'd1) : acc_ff;
      ovf = !((&sgn[127:95]) || !(|sgn[127:95]));

      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      neg_in  = neg_ff;
      ma_in   = ma_ff;
      mb_in   = mb_ff;
      pp_in   = pp_ff;
      acc_in  = acc_ff;
      rsp_in  = rsp_ff;
      rsp_in.done = 1'b0;

      if (mul_req.start) begin
         busy_in = 1'b1;
         cnt_in  = 3'd0;
         neg_in  = mul_req.op_a[DATA_W-1] ^ mul_req.op_b[DATA_W-1];
         ma_in   = mul_req.op_a[DATA_W-1] ? (DATA_W'(0) - mul_req.op_a) : mul_req.op_a;
         mb_in   = mul_req.op_b[DATA_W-1] ? (DATA_W'(0) - mul_req.op_b) : mul_req.op_b;
         acc_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 3'd1;
         if (cnt_ff <= 3'd3) begin
            pp_in = a_part * b_part;
         end
         acc_in = acc_ff + addend;
         if (cnt_ff == 3'd5) begin
            busy_in     = 1'b0;
            rsp_in.done = 1'b1;
            rsp_in.sat  = ovf;
            rsp_in.prod = ovf ? (sgn[127] ? S_MIN : S_MAX) : sgn[95:32];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         cnt_ff      <= 3'd0;
         rsp_ff.done <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         cnt_ff      <= cnt_in;
         rsp_ff.done <= rsp_in.done;
      end
      rsp_ff.sat  <= rsp_in.sat;
      rsp_ff.prod <= rsp_in.prod;
   end

   always_ff @(posedge clock) begin
      neg_ff      <= neg_in;
      ma_ff       <= ma_in;
      mb_ff       <= mb_in;
      pp_ff       <= pp_in;
      acc_ff      <= acc_in;
   end

   assign mul_rsp = rsp_ff;

endmodule

FILE: design/sparse_grid_second_moment.sv
// Second moment of a sparse grid function with linear boundary basis, Q32.32.
// A load item ends in its transfer cycle. A term item runs longer with bounds than without, and
// longer still on a point's last dimension; each multiply holds the shared 32x32 unit.
// One item is in work at a time; a finished result waits in an output register meanwhile.
// Synchronous active-high reset clears the bound valid bits at once (no sweep), the sum,
// the saturation flag, use_bounds, and sets the point product to one.
module sparse_grid_second_moment
   import sgsm_pkg::*;
#(
   parameter int MAX_DIMS  = MAX_DIMS_DEF,
   parameter int MAX_LEVEL = MAX_LEVEL_DEF
)
(
   input  logic         clock,
   input  logic         reset,
   sgsm_req_if.sink     req_chan,
   sgsm_rsp_if.source   rsp_chan,
   input  logic         csr_we,
   input  logic         csr_wdata
);

   // Address width of the bound tables; a one-entry table still gets one address bit.
   localparam int TBL_AW = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
   localparam logic [LEVEL_W-1:0] LV_CAP = LEVEL_W'((MAX_LEVEL < 15) ? MAX_LEVEL : 15);

   // Sequencer steps. The bounded moment is
   // ((w*w)*m2 + 2*((w*lower)*m1)) + (lower*lower)*q, one operation per step.
   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_BASIS = 4'd1;
   localparam logic [3:0] ST_WIDTH = 4'd2;
   localparam logic [3:0] ST_M_WW  = 4'd3;
   localparam logic [3:0] ST_M_T1  = 4'd4;
   localparam logic [3:0] ST_M_WL  = 4'd5;
   localparam logic [3:0] ST_M_T2  = 4'd6;
   localparam logic [3:0] ST_A_T2  = 4'd7;
   localparam logic [3:0] ST_M_LL  = 4'd8;
   localparam logic [3:0] ST_M_T3  = 4'd9;
   localparam logic [3:0] ST_A_S12 = 4'd10;
   localparam logic [3:0] ST_A_S3  = 4'd11;
   localparam logic [3:0] ST_M_PP  = 4'd12;
   localparam logic [3:0] ST_M_AL  = 4'd13;
   localparam logic [3:0] ST_A_SUM = 4'd14;

   // Control state.
   logic [3:0]          state_ff, state_in;
   logic                mul_wait_ff, mul_wait_in;
   logic                use_bounds_ff;
   logic                sat_flag_ff, sat_flag_in;
   logic [DATA_W-1:0]   pp_ff, pp_in;
   logic [DATA_W-1:0]   sum_ff, sum_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [MAX_DIMS-1:0] tbl_valid_ff;

   // Item and working registers.
   logic [LEVEL_W-1:0]  lv_ff, lv_in;
   logic [INDEX_W-1:0]  idx_ff, idx_in;
   logic [DATA_W-1:0]   alpha_ff, alpha_in;
   logic                last_dim_ff, last_dim_in;
   logic                last_point_ff, last_point_in;
   logic [DATA_W-1:0]   xl_ff, xl_in;
   logic [DATA_W-1:0]   xu_ff, xu_in;
   logic [DATA_W-1:0]   m1_ff, m1_in;
   logic [DATA_W-1:0]   m2_ff, m2_in;
   logic [DATA_W-1:0]   q_ff, q_in;
   logic [DATA_W-1:0]   w_ff, w_in;
   logic [DATA_W-1:0]   t1_ff, t1_in;
   logic [DATA_W-1:0]   t2_ff, t2_in;
   logic [DATA_W-1:0]   t3_ff, t3_in;
   logic [DATA_W-1:0]   rsp_moment_ff, rsp_moment_in;
   logic                rsp_sat_ff, rsp_sat_in;

   // Bound tables with registered read data.
   logic [DATA_W-1:0]   lo_mem [MAX_DIMS];
   logic [DATA_W-1:0]   up_mem [MAX_DIMS];
   logic [DATA_W-1:0]   lo_rd_ff, up_rd_ff;
   logic                rd_ok_ff;

   // Request decode.
   logic                req_xfer;
   logic [6:0]          dim_x;
   logic                dim_in_range;
   logic [TBL_AW-1:0]   tbl_addr;
   logic                load_we;
   logic                term_rd;

   // Basis moments.
   logic [LEVEL_W-1:0]  lv_c;
   logic                lv0;
   logic [31:0]         sq;
   logic [5:0]          sh3;
   logic [4:0]          sh2;
   logic [DATA_W-1:0]   m2_shift, m1_shift, q_shift;
   logic [DATA_W-1:0]   m2_val, m1_val, q_val;
   logic                m2_sat;

   // Shared saturating adder.
   logic [DATA_W-1:0]   add_a, add_b;
   logic                add_sub;
   logic [DATA_W:0]     add_sum;
   logic                add_ovf;
   logic [DATA_W-1:0]   add_val;

   // Shared multiplier.
   qmul_req_type        mul_req;
   qmul_rsp_type        mul_rsp;
   logic                is_mul;

   sgsm_qmul u_qmul (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   assign req_chan.ready     = (state_ff == ST_IDLE);
   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.moment    = rsp_moment_ff;
   assign rsp_chan.saturated = rsp_sat_ff;

   assign req_xfer     = req_chan.valid && req_chan.ready;
   assign dim_x        = {3'd0, req_chan.dim};
   assign dim_in_range = (dim_x < 7'(MAX_DIMS));
   assign tbl_addr     = dim_x[TBL_AW-1:0];
   assign load_we      = req_xfer && (req_chan.cmd == CMD_LOAD) && dim_in_range;
   assign term_rd      = req_xfer && (req_chan.cmd == CMD_TERM);

   // Basis moments of the latched level and index. Level is clamped first.
   always_comb begin
      lv_c     = (lv_ff > LV_CAP) ? LV_CAP : lv_ff;
      lv0      = (lv_c == '0);
      sq       = {16'd0, idx_ff} * {16'd0, idx_ff};
      sh3      = {2'd0, lv_c} + {1'b0, lv_c, 1'b0};
      sh2      = {lv_c, 1'b0};
      // The square is kept modulo 2^32 before the shift, as wide as the Q32.32 word allows.
      m2_shift = {sq, M2_SIXTH} >> sh3;
      m1_shift = {16'd0, idx_ff, 32'd0} >> sh2;
      q_shift  = Q_ONE >> lv_c;
      m2_sat   = 1'b0;
      if (lv0 && (idx_ff == '0)) begin
         m2_val = M2_L0_I0;
         m1_val = M1_L0_I0;
      end else if (lv0 && (idx_ff == INDEX_W'(1))) begin
         m2_val = M2_L0_I1;
         m1_val = M1_L0_I1;
      end else begin
         m2_sat = m2_shift[DATA_W-1];
         m2_val = m2_sat ? S_MAX : m2_shift;
         m1_val = m1_shift;
      end
      q_val = lv0 ? Q_L0 : q_shift;
   end

   // Operand selection for the shared adder and multiplier.
   always_comb begin
      add_a   = sum_ff;
      add_b   = t1_ff;
      add_sub = 1'b0;
      mul_req.op_a = pp_ff;
      mul_req.op_b = m2_ff;
      unique case (state_ff)
         ST_WIDTH: begin
            add_a   = xu_ff;
            add_b   = xl_ff;
            add_sub = 1'b1;
         end
         ST_A_T2: begin
            add_a = t2_ff;
            add_b = t2_ff;
         end
         ST_A_S12: begin
            add_a = t1_ff;
            add_b = t2_ff;
         end
         ST_A_S3: begin
            add_a = t1_ff;
            add_b = t3_ff;
         end
         ST_M_WW: begin
            mul_req.op_a = w_ff;
            mul_req.op_b = w_ff;
         end
         ST_M_T1: begin
            mul_req.op_a = t1_ff;
            mul_req.op_b = m2_ff;
         end
         ST_M_WL: begin
            mul_req.op_a = w_ff;
            mul_req.op_b = xl_ff;
         end
         ST_M_T2: begin
            mul_req.op_a = t2_ff;
            mul_req.op_b = m1_ff;
         end
         ST_M_LL: begin
            mul_req.op_a = xl_ff;
            mul_req.op_b = xl_ff;
         end
         ST_M_T3: begin
            mul_req.op_a = t3_ff;
            mul_req.op_b = q_ff;
         end
         ST_M_PP: begin
            mul_req.op_a = pp_ff;
            mul_req.op_b = use_bounds_ff ? t1_ff : m2_ff;
         end
         ST_M_AL: begin
            mul_req.op_a = alpha_ff;
            mul_req.op_b = pp_ff;
         end
         default: begin
         end
      endcase
      is_mul = (state_ff == ST_M_WW) || (state_ff == ST_M_T1) || (state_ff == ST_M_WL) ||
               (state_ff == ST_M_T2) || (state_ff == ST_M_LL) || (state_ff == ST_M_T3) ||
               (state_ff == ST_M_PP) || (state_ff == ST_M_AL);
      mul_req.start = is_mul && !mul_wait_ff;
   end

   // The sum is formed one bit wider, so the true sign and any overflow are both visible.
   // Subtracting the most negative value is exact in that width.
   assign add_sum = {add_a[DATA_W-1], add_a} +
                    (add_sub ? ((DATA_W+1)'(0) - {add_b[DATA_W-1], add_b})
                             : {add_b[DATA_W-1], add_b});
   assign add_ovf = add_sum[DATA_W] != add_sum[DATA_W-1];
   assign add_val = add_ovf ? (add_sum[DATA_W] ? S_MIN : S_MAX) : add_sum[DATA_W-1:0];

   // Sequencer.
   always_comb begin
      state_in      = state_ff;
      mul_wait_in   = mul_wait_ff;
      sat_flag_in   = sat_flag_ff | (mul_rsp.done & mul_rsp.sat);
      pp_in         = pp_ff;
      sum_in        = sum_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      lv_in         = lv_ff;
      idx_in        = idx_ff;
      alpha_in      = alpha_ff;
      last_dim_in   = last_dim_ff;
      last_point_in = last_point_ff;
      xl_in         = xl_ff;
      xu_in         = xu_ff;
      m1_in         = m1_ff;
      m2_in         = m2_ff;
      q_in          = q_ff;
      w_in          = w_ff;
      t1_in         = t1_ff;
      t2_in         = t2_ff;
      t3_in         = t3_ff;
      rsp_moment_in = rsp_moment_ff;
      rsp_sat_in    = rsp_sat_ff;

      if (is_mul) begin
         if (!mul_wait_ff) begin
            mul_wait_in = 1'b1;
         end else if (mul_rsp.done) begin
            mul_wait_in = 1'b0;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            // Loads are finished in the transfer cycle; terms start the sequence.
            if (term_rd) begin
               lv_in         = req_chan.level;
               idx_in        = req_chan.index;
               alpha_in      = req_chan.alpha;
               last_dim_in   = req_chan.last_dim;
               last_point_in = req_chan.last_point;
               state_in      = ST_BASIS;
            end
         end
         ST_BASIS: begin
            // A term at a dimension without a stored load reads zero bounds.
            xl_in       = rd_ok_ff ? lo_rd_ff : '0;
            xu_in       = rd_ok_ff ? up_rd_ff : '0;
            m1_in       = m1_val;
            m2_in       = m2_val;
            q_in        = q_val;
            sat_flag_in = sat_flag_in | m2_sat;
            state_in    = use_bounds_ff ? ST_WIDTH : ST_M_PP;
         end
         ST_WIDTH: begin
            // A lower bound at the most negative value always counts as a saturation.
            w_in        = add_val;
            sat_flag_in = sat_flag_in | add_ovf | (xl_ff == S_MIN);
            state_in    = ST_M_WW;
         end
         ST_M_WW: begin
            if (mul_rsp.done) begin
               t1_in    = mul_rsp.prod;
               state_in = ST_M_T1;
            end
         end
         ST_M_T1: begin
            if (mul_rsp.done) begin
               t1_in    = mul_rsp.prod;
               state_in = ST_M_WL;
            end
         end
         ST_M_WL: begin
            if (mul_rsp.done) begin
               t2_in    = mul_rsp.prod;
               state_in = ST_M_T2;
            end
         end
         ST_M_T2: begin
            if (mul_rsp.done) begin
               t2_in    = mul_rsp.prod;
               state_in = ST_A_T2;
            end
         end
         ST_A_T2: begin
            t2_in       = add_val;
            sat_flag_in = sat_flag_in | add_ovf;
            state_in    = ST_M_LL;
         end
         ST_M_LL: begin
            if (mul_rsp.done) begin
               t3_in    = mul_rsp.prod;
               state_in = ST_M_T3;
            end
         end
         ST_M_T3: begin
            if (mul_rsp.done) begin
               t3_in    = mul_rsp.prod;
               state_in = ST_A_S12;
            end
         end
         ST_A_S12: begin
            t1_in       = add_val;
            sat_flag_in = sat_flag_in | add_ovf;
            state_in    = ST_A_S3;
         end
         ST_A_S3: begin
            t1_in       = add_val;
            sat_flag_in = sat_flag_in | add_ovf;
            state_in    = ST_M_PP;
         end
         ST_M_PP: begin
            if (mul_rsp.done) begin
               pp_in    = mul_rsp.prod;
               state_in = last_dim_ff ? ST_M_AL : ST_IDLE;
            end
         end
         ST_M_AL: begin
            if (mul_rsp.done) begin
               t1_in    = mul_rsp.prod;
               state_in = ST_A_SUM;
            end
         end
         ST_A_SUM: begin
            if (!last_point_ff) begin
               sum_in      = add_val;
               sat_flag_in = sat_flag_in | add_ovf;
               pp_in       = Q_ONE;
               state_in    = ST_IDLE;
            end else if (!rsp_valid_ff || rsp_chan.ready) begin
               // The grid is finished: hand the sum over and start a fresh one.
               rsp_moment_in = add_val;
               rsp_sat_in    = sat_flag_ff | add_ovf;
               rsp_valid_in  = 1'b1;
               sum_in        = '0;
               sat_flag_in   = 1'b0;
               pp_in         = Q_ONE;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mul_wait_ff   <= 1'b0;
         use_bounds_ff <= 1'b0;
         sat_flag_ff   <= 1'b0;
         pp_ff         <= Q_ONE;
         sum_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         tbl_valid_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         mul_wait_ff  <= mul_wait_in;
         sat_flag_ff  <= sat_flag_in;
         pp_ff        <= pp_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            use_bounds_ff <= csr_wdata;
         end
         if (load_we) begin
            tbl_valid_ff[tbl_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      lv_ff         <= lv_in;
      idx_ff        <= idx_in;
      alpha_ff      <= alpha_in;
      last_dim_ff   <= last_dim_in;
      last_point_ff <= last_point_in;
      xl_ff         <= xl_in;
      xu_ff         <= xu_in;
      m1_ff         <= m1_in;
      m2_ff         <= m2_in;
      q_ff          <= q_in;
      w_ff          <= w_in;
      t1_ff         <= t1_in;
      t2_ff         <= t2_in;
      t3_ff         <= t3_in;
      rsp_moment_ff <= rsp_moment_in;
      rsp_sat_ff    <= rsp_sat_in;
   end

   // Bound tables: written by loads, read once per term in its transfer cycle.
   always_ff @(posedge clock) begin
      if (load_we) begin
         lo_mem[tbl_addr] <= req_chan.lower;
         up_mem[tbl_addr] <= req_chan.upper;
      end
      if (term_rd) begin
         lo_rd_ff <= lo_mem[tbl_addr];
         up_rd_ff <= up_mem[tbl_addr];
         rd_ok_ff <= dim_in_range && tbl_valid_ff[tbl_addr];
      end
   end

endmodule

FILE: verif/testbench.sv
// Self-checking testbench for the sparse grid second moment block, with its own scoreboard.
`timescale 1ns / 1ps

module testbench;
   import sgsm_pkg::*;

   // Q32.32 values used by the prediction. They are written out here rather than taken
   // from the package, so a wrong constant in the design cannot hide itself.
   localparam logic [63:0] FIX_ONE  = 64'h0000_0001_0000_0000;
   localparam logic [63:0] FIX_MAX  = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] FIX_MIN  = 64'h8000_0000_0000_0000;
   localparam logic [63:0] QUARTER  = 64'd1073741824;
   localparam logic [63:0] TWELFTH  = 64'd357913941;
   localparam logic [63:0] SIXTH    = 64'd715827882;
   localparam logic [63:0] THIRD    = 64'd1431655765;
   localparam logic [63:0] HALF     = 64'd2147483648;

   // The drain wait is long enough for any term that produces no result to leave the datapath.
   localparam int DRAIN_CYCLES = 100;
   // Length of the long response stall, in cycles.
   localparam int RSP_HOLD     = 3000;
   // Cycles without any transfer on either channel before the run is declared hung.
   localparam int STALL_LIMIT  = 20000;

   typedef struct {
      logic                cmd;
      logic [DIM_W-1:0]    dim;
      logic [LEVEL_W-1:0]  level;
      logic [INDEX_W-1:0]  index;
      logic [DATA_W-1:0]   lower;
      logic [DATA_W-1:0]   upper;
      logic [DATA_W-1:0]   alpha;
      logic                last_dim;
      logic                last_point;
   } grid_item_type;

   typedef struct {
      logic [DATA_W-1:0] moment;
      logic              saturated;
   } moment_result_type;

   // The scoreboard keeps its own copy of the bound tables, the running point product,
   // the running sum and the saturation flag. Every accepted request advances that copy;
   // a request that closes a grid queues the moment the block has to send back.
   class moment_scoreboard;
      logic [DATA_W-1:0] lower_tab [MAX_DIMS_DEF];
      logic [DATA_W-1:0] upper_tab [MAX_DIMS_DEF];
      logic [DATA_W-1:0] point_prod;
      logic [DATA_W-1:0] moment_acc;
      bit                sat_seen;
      bit                bounds_on;
      moment_result_type moment_q[$];
      int unsigned       errors;

      function new();
         foreach (lower_tab[d]) begin
            lower_tab[d] = '0;
            upper_tab[d] = '0;
         end
         point_prod = FIX_ONE;
         moment_acc = '0;
         sat_seen   = 1'b0;
         bounds_on  = 1'b0;
         errors     = 0;
      endfunction

      function int outstanding();
         return moment_q.size();
      endfunction

      // Saturating signed add.
      function logic [63:0] fix_add(logic [63:0] a, logic [63:0] b);
         logic [63:0] s;
         s = a + b;
         if (a[63] == b[63] && s[63] != a[63]) begin
            sat_seen = 1'b1;
            return a[63] ? FIX_MIN : FIX_MAX;
         end
         return s;
      endfunction

      // Exact product, floor shift by 32, saturate to 64 bits.
      function logic [63:0] fix_mul(logic [63:0] a, logic [63:0] b);
         logic signed [127:0] wide;
         logic signed [127:0] shifted;
         wide    = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
         shifted = wide >>> 32;
         if (shifted[127:63] != {65{shifted[63]}}) begin
            sat_seen = 1'b1;
            return wide[127] ? FIX_MIN : FIX_MAX;
         end
         return shifted[63:0];
      endfunction

      // Moment of one dimension of a grid point, raw or through the stored bounds.
      function logic [63:0] grid_term_moment(logic [DIM_W-1:0] dim, logic [LEVEL_W-1:0] lv,
                                             logic [INDEX_W-1:0] idx);
         logic [63:0] idx64, m2, m1, q, w, xl, xu, t1, t2, t3;
         idx64 = {48'd0, idx};
         if (lv == 0 && idx64 == 0) begin
            m2 = QUARTER;
         end else if (lv == 0 && idx64 == 1) begin
            m2 = TWELFTH;
         end else begin
            // The square is shifted into the integer part in 64 bits and may wrap.
            m2 = (((idx64 * idx64) << 32) + SIXTH) >> (3 * lv);
            if (m2 > FIX_MAX) begin
               sat_seen = 1'b1;
               m2 = FIX_MAX;
            end
         end
         if (!bounds_on) return m2;
         if (lv == 0 && idx64 == 0) m1 = THIRD;
         else if (lv == 0 && idx64 == 1) m1 = SIXTH;
         else m1 = (idx64 << 32) >> (2 * lv);
         q = (lv == 0) ? HALF : (FIX_ONE >> lv);
         // The dimension field cannot address past the table, so no range check is needed.
         xl = lower_tab[dim];
         xu = upper_tab[dim];
         w = fix_add(xu, 64'd0 - xl);
         // The most negative lower bound cannot be negated; the width is then built in two
         // steps, and the first attempt above still counts toward the saturation flag.
         if (xl == FIX_MIN) w = fix_add(fix_add(xu, FIX_MAX), 64'd1);
         t1 = fix_mul(fix_mul(w, w), m2);
         t2 = fix_mul(fix_mul(w, xl), m1);
         t2 = fix_add(t2, t2);
         t3 = fix_mul(fix_mul(xl, xl), q);
         return fix_add(fix_add(t1, t2), t3);
      endfunction

      function void note_request(grid_item_type it);
         moment_result_type res;
         if (it.cmd == CMD_LOAD) begin
            lower_tab[it.dim] = it.lower;
            upper_tab[it.dim] = it.upper;
            return;
         end
         point_prod = fix_mul(point_prod, grid_term_moment(it.dim, it.level, it.index));
         if (!it.last_dim) return;
         moment_acc = fix_add(moment_acc, fix_mul(it.alpha, point_prod));
         point_prod = FIX_ONE;
         // A last-point mark only counts on the point's last dimension.
         if (!it.last_point) return;
         res.moment    = moment_acc;
         res.saturated = sat_seen;
         moment_q.push_back(res);
         moment_acc = '0;
         sat_seen   = 1'b0;
      endfunction

      function void check_result(logic [DATA_W-1:0] got_moment, logic got_sat);
         moment_result_type want;
         if (moment_q.size() == 0) begin
            $error("moment: expected none, actual %h", got_moment);
            errors++;
            return;
         end
         want = moment_q.pop_front();
         if (got_moment !== want.moment) begin
            $error("moment: expected %h, actual %h", want.moment, got_moment);
            errors++;
         end
         if (got_sat !== want.saturated) begin
            $error("saturated: expected %0b, actual %0b", want.saturated, got_sat);
            errors++;
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   logic csr_we;
   logic csr_wdata;

   sgsm_req_if req_bus ();
   sgsm_rsp_if rsp_bus ();

   sparse_grid_second_moment dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   moment_scoreboard sb = new();

   // Idle rates in percent for the request sender and the response receiver. They are
   // changed between phases by the main sequence and read every cycle by the drivers.
   int unsigned src_idle_pct = 0;
   int unsigned rsp_idle_pct = 0;
   int unsigned items_sent   = 0;
   // Set by the main sequence to ask the receiver for one long stall.
   bit          hold_pending = 1'b0;

   always #1 clock = ~clock;

   // A random Q32.32 bound. Most are small, so that widths and squares stay in range and
   // the bounded moment carries real information; the rest cover every bit.
   function automatic logic [63:0] pick_bound();
      logic [31:0] whole;
      if ($urandom_range(99) < 80) begin
         whole = $urandom_range(0, 16) - 8;
         return {whole, $urandom()};
      end
      return {$urandom(), $urandom()};
   endfunction

   // A request with random content. The grid sequencer overrides the dimension marks.
   function automatic grid_item_type random_item(logic cmd);
      grid_item_type it;
      logic [31:0]   whole;
      int unsigned   dice;
      it.cmd   = cmd;
      it.dim   = DIM_W'($urandom_range(0, 15));
      it.level = LEVEL_W'(($urandom_range(99) < 70) ? $urandom_range(0, 4)
                                                     : $urandom_range(0, 15));
      dice = $urandom_range(99);
      if (dice < 50) begin
         // An index that exists on this level: 0 or 1 on level 0, odd below 2^level above.
         if (it.level == 0) it.index = INDEX_W'($urandom_range(0, 1));
         else it.index = INDEX_W'($urandom_range(0, (1 << it.level) - 1) | 1);
      end else if (dice < 75) begin
         it.index = INDEX_W'($urandom_range(0, 3));
      end else begin
         it.index = INDEX_W'($urandom_range(0, 65535));
      end
      it.lower = pick_bound();
      if ($urandom_range(99) < 70) it.upper = it.lower + {$urandom_range(0, 4), $urandom()};
      else it.upper = pick_bound();
      if ($urandom_range(99) < 80) begin
         whole    = $urandom_range(0, 8) - 4;
         it.alpha = {whole, $urandom()};
      end else begin
         it.alpha = {$urandom(), $urandom()};
      end
      it.last_dim   = 1'($urandom_range(0, 1));
      it.last_point = 1'($urandom_range(0, 1));
      return it;
   endfunction

   function automatic grid_item_type make_term(logic [3:0] dim, logic [3:0] lv,
                                               logic [15:0] idx, logic [63:0] alpha,
                                               logic ld, logic lp);
      grid_item_type it;
      it.cmd        = CMD_TERM;
      it.dim        = dim;
      it.level      = lv;
      it.index      = idx;
      it.lower      = '0;
      it.upper      = '0;
      it.alpha      = alpha;
      it.last_dim   = ld;
      it.last_point = lp;
      return it;
   endfunction

   // Loads carry set point marks and a nonzero coefficient, which the block must ignore.
   function automatic grid_item_type make_load(logic [3:0] dim, logic [63:0] lo,
                                               logic [63:0] hi);
      grid_item_type it;
      it.cmd        = CMD_LOAD;
      it.dim        = dim;
      it.level      = 4'hF;
      it.index      = 16'hFFFF;
      it.lower      = lo;
      it.upper      = hi;
      it.alpha      = FIX_MAX;
      it.last_dim   = 1'b1;
      it.last_point = 1'b1;
      return it;
   endfunction

   // Offers one request and returns at the rising edge where it transfers. Inputs are
   // only changed at falling edges; valid stays high until the next falling edge, where
   // the following call either replaces the payload or drops valid while it idles.
   task automatic send_item(grid_item_type it);
      @(negedge clock);
      while ($urandom_range(99) < src_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid      = 1'b1;
      req_bus.cmd        = it.cmd;
      req_bus.dim        = it.dim;
      req_bus.level      = it.level;
      req_bus.index      = it.index;
      req_bus.lower      = it.lower;
      req_bus.upper      = it.upper;
      req_bus.alpha      = it.alpha;
      req_bus.last_dim   = it.last_dim;
      req_bus.last_point = it.last_point;
      @(posedge clock);
      while (req_bus.ready !== 1'b1) @(posedge clock);
      sb.note_request(it);
      items_sent++;
   endtask

   // Stops offering requests and waits until every expected moment has come back. With
   // drain set it also waits out a term that is still in the datapath without a result,
   // which must be done before the bounds mode may change.
   task automatic settle_block(bit drain);
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (sb.outstanding() != 0) @(negedge clock);
      if (drain) repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Called at a falling edge with the block idle.
   task automatic write_bounds_mode(logic mode);
      csr_we    = 1'b1;
      csr_wdata = mode;
      @(negedge clock);
      csr_we       = 1'b0;
      sb.bounds_on = mode;
   endtask

   // Random traffic. Most of it is well-formed grids: a few points, each with a few
   // dimension terms, the last term of each point marked, the last point of the grid
   // marked. Loads with fresh bounds and loose terms with random marks are mixed in, and
   // now and then a last-point mark lands on a term that does not end its point.
   task automatic run_random(int unsigned count, bit stall_results, bit drain_midway);
      int unsigned   goal, half, n_points, n_dims, dice;
      bit            midway_done;
      grid_item_type it;
      goal        = items_sent + count;
      half        = items_sent + count / 2;
      midway_done = 1'b0;
      while (items_sent < goal) begin
         if (!midway_done && items_sent >= half) begin
            midway_done = 1'b1;
            // The long stall lets the output register and the datapath fill up while
            // requests keep coming, so the block has to push back on its input.
            if (stall_results) hold_pending = 1'b1;
            if (drain_midway) settle_block(1'b0);
         end
         dice = $urandom_range(99);
         if (dice < 10) begin
            send_item(random_item(CMD_LOAD));
         end else if (dice < 15) begin
            send_item(random_item(CMD_TERM));
         end else begin
            n_points = $urandom_range(1, 3);
            for (int p = 0; p < n_points; p++) begin
               n_dims = $urandom_range(1, 4);
               for (int d = 0; d < n_dims; d++) begin
                  it            = random_item(CMD_TERM);
                  it.last_dim   = (d == n_dims - 1);
                  it.last_point = it.last_dim && (p == n_points - 1);
                  if ($urandom_range(19) == 0) it.last_point = 1'b1;
                  send_item(it);
               end
            end
         end
      end
   endtask

   // Response side: ready is chosen at each falling edge, and a transfer seen at the
   // rising edge is handed to the scoreboard. A requested long stall is counted here.
   initial begin
      int unsigned hold_left;
      hold_left     = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_pending) begin
            hold_pending = 1'b0;
            hold_left    = RSP_HOLD;
         end
         if (hold_left > 0) begin
            rsp_bus.ready = 1'b0;
            hold_left--;
         end else begin
            rsp_bus.ready = ($urandom_range(99) >= rsp_idle_pct);
         end
         @(posedge clock);
         if (reset === 1'b0 && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)
            sb.check_result(rsp_bus.moment, rsp_bus.saturated);
      end
   end

   // Hang detection: any cycle with a transfer on either channel resets the count.
   initial begin
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      @(negedge reset);
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("Regression FAIL");
      $finish;
   end

   // Main sequence.
   initial begin
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_wdata          = 1'b0;
      req_bus.valid      = 1'b0;
      req_bus.cmd        = CMD_LOAD;
      req_bus.dim        = '0;
      req_bus.level      = '0;
      req_bus.index      = '0;
      req_bus.lower      = '0;
      req_bus.upper      = '0;
      req_bus.alpha      = '0;
      req_bus.last_dim   = 1'b0;
      req_bus.last_point = 1'b0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Raw basis moments: the level-0 special values, the top level with the largest
      // index, a level-0 index whose square overflows the moment, a last-point mark
      // without the last dimension, and the coefficient at both extremes.
      write_bounds_mode(1'b0);
      send_item(make_term(4'd0, 4'd0, 16'd0, FIX_ONE, 1'b1, 1'b1));
      send_item(make_term(4'd1, 4'd0, 16'd1, FIX_ONE, 1'b0, 1'b0));
      send_item(make_term(4'd2, 4'd1, 16'd1, FIX_ONE, 1'b0, 1'b0));
      send_item(make_term(4'd3, 4'd15, 16'hFFFF, FIX_MAX, 1'b1, 1'b1));
      send_item(make_term(4'd4, 4'd0, 16'hFFFF, FIX_ONE, 1'b0, 1'b1));
      send_item(make_term(4'd5, 4'd3, 16'd5, FIX_MIN, 1'b1, 1'b1));
      send_item(make_term(4'd15, 4'd15, 16'h8000, FIX_ONE, 1'b1, 1'b0));
      send_item(make_term(4'd6, 4'd2, 16'd3, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, 1'b1));
      settle_block(1'b1);

      // Bounded moments: a unit interval, an interval from -2 to 3, the full signed range
      // with the most negative lower bound, a reversed full range, a dimension that was
      // never loaded and so reads zero bounds, and the deepest level on a loaded dimension.
      write_bounds_mode(1'b1);
      send_item(make_load(4'd0, 64'd0, FIX_ONE));
      send_item(make_load(4'd3, 64'hFFFF_FFFE_0000_0000, 64'h0000_0003_0000_0000));
      send_item(make_load(4'd15, FIX_MIN, FIX_MAX));
      send_item(make_term(4'd0, 4'd0, 16'd0, FIX_ONE, 1'b0, 1'b0));
      send_item(make_term(4'd3, 4'd1, 16'd1, FIX_ONE, 1'b1, 1'b1));
      send_item(make_term(4'd15, 4'd2, 16'd3, FIX_ONE, 1'b1, 1'b1));
      send_item(make_term(4'd7, 4'd4, 16'd9, FIX_ONE, 1'b1, 1'b1));
      send_item(make_term(4'd3, 4'd0, 16'd1, FIX_MAX, 1'b0, 1'b0));
      send_item(make_term(4'd0, 4'd5, 16'd31, 64'hFFFF_FFFF_0000_0000, 1'b1, 1'b1));
      send_item(make_load(4'd15, FIX_MAX, FIX_MIN));
      send_item(make_term(4'd15, 4'd0, 16'd0, FIX_ONE, 1'b1, 1'b1));
      send_item(make_load(4'd9, 64'hFFFF_FFFF_8000_0000, 64'h0000_0000_8000_0000));
      send_item(make_term(4'd9, 4'd15, 16'hFFFF, FIX_ONE, 1'b1, 1'b1));
      settle_block(1'b1);

      // Bounded, slow receiver; halfway through the sender waits for every result.
      src_idle_pct = 20;
      rsp_idle_pct = 65;
      run_random(400, 1'b0, 1'b1);
      settle_block(1'b1);

      // Raw moments, slow sender.
      write_bounds_mode(1'b0);
      src_idle_pct = 65;
      rsp_idle_pct = 20;
      run_random(400, 1'b0, 1'b0);
      settle_block(1'b1);

      // Bounded, no idling on either side, with one long stall of the receiver.
      write_bounds_mode(1'b1);
      src_idle_pct = 0;
      rsp_idle_pct = 0;
      run_random(400, 1'b1, 1'b0);
      settle_block(1'b1);

      if (sb.errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

FILE: filelist.f
design/sgsm_pkg.sv
design/sgsm_req_if.sv
design/sgsm_rsp_if.sv
design/sgsm_qmul.sv
design/sparse_grid_second_moment.sv
verif/testbench.sv
